### rtl/ifv_pkg.sv
// Shared types and constants for the IPC frame validator.
package ifv_pkg;

    localparam int CNT_W = 34;

    localparam logic [CNT_W-1:0] HDR_LEN = 34'd10;
    localparam logic [CNT_W-1:0] CNT_MAX = 34'h3_FFFF_FFFF;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_INVALID    = 2'd1,
        ST_COMPLETE   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_payload;
        logic        end_of_buffer;
        status_t     frame_status;
        logic [31:0] payload_length;
    } out_beat_t;

    // Per-byte control from the frame tracker to the UTF-8 checker.
    typedef struct packed {
        logic       feed;
        logic       clear;
        logic       bom_chk;
        logic [1:0] bom_idx;
    } utf8_ctl_t;

    // Checker state after the current byte, for the end-of-buffer decision.
    typedef struct packed {
        logic bad;
        logic pending;
        logic bom_full;
    } utf8_stat_t;

endpackage

### rtl/ipc_frame_validator_core.sv
// Top level of the IPC frame validator: input register, frame tracker, output register.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------------
//  input     | in_valid / in_ready         | in_data  (data_byte, buffer_end)
//  output    | out_valid / out_ready       | out_data (out_byte, is_payload, ...)
//  config    | cfg_wr_en                   | cfg_wr_data (max_payload)
//
// One beat per cycle sustained while out_ready is high; a byte's result goes from the input
// register through one pass of the frame tracker into the output register.
// rst_n clears all frame state and sets max_payload to 1048576.
// A stalled output holds its beat; the input register can still take one beat while a
// result waits, and in_ready drops only when both registers are full.
module ipc_frame_validator_core
    import ifv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic        a_valid_reg;
    in_beat_t    a_beat_reg;
    logic        b_valid_reg;
    out_beat_t   b_beat_reg;
    logic [31:0] max_payload_reg;

    logic        b_free;
    logic        advance;
    out_beat_t   result;

    assign b_free   = !b_valid_reg || out_ready;
    assign advance  = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || b_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_beat_reg <= in_data;
        end
        if (advance)
        begin
            b_beat_reg <= result;
        end
    end

    ifv_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .beat        (a_beat_reg),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    assign out_valid = b_valid_reg;
    assign out_data  = b_beat_reg;

    // status is only reported on the last beat of a buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_buffer |-> out_data.frame_status == ST_INCOMPLETE)
    else $error("frame status set on a beat that is not the end of the buffer");

    // a complete frame always carries a length inside the configured limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_status == ST_COMPLETE |->
            out_data.payload_length != 32'd0 && out_data.payload_length <= max_payload_reg)
    else $error("complete frame with out-of-range length");

    // input back-pressure only when both pipeline registers hold beats
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> a_valid_reg && b_valid_reg && !out_ready)
    else $error("in_ready low with a free pipeline slot");

    // a beat moved forward shows up at the output on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
    else $error("advanced beat missing at the output");

endmodule

### rtl/ifv_utf8.sv
// UTF-8 sequence checker, zero-byte check and byte-order-mark match for the payload.
module ifv_utf8
    import ifv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  utf8_ctl_t  ctl,
    input  logic [7:0] data_byte,
    output utf8_stat_t stat
);

    typedef enum logic [2:0] {
        RNG_ANY  = 3'd0,
        RNG_A0BF = 3'd1,
        RNG_809F = 3'd2,
        RNG_90BF = 3'd3,
        RNG_808F = 3'd4
    } range_t;

    logic       bad_reg, bad_next;
    logic [1:0] pend_reg, pend_next;
    range_t     rng_reg, rng_next;
    logic [1:0] bom_reg, bom_next;

    function automatic logic cont_ok(input logic [7:0] b, input range_t r);
        logic ok;
        case (r)
            RNG_A0BF: ok = b inside {[8'hA0:8'hBF]};
            RNG_809F: ok = b inside {[8'h80:8'h9F]};
            RNG_90BF: ok = b inside {[8'h90:8'hBF]};
            RNG_808F: ok = b inside {[8'h80:8'h8F]};
            default:  ok = b inside {[8'h80:8'hBF]};
        endcase
        return ok;
    endfunction

    function automatic logic [7:0] bom_byte(input logic [1:0] i);
        logic [7:0] v;
        case (i)
            2'd0:    v = 8'hEF;
            2'd1:    v = 8'hBB;
            default: v = 8'hBF;
        endcase
        return v;
    endfunction

    always_comb
    begin
        bad_next  = bad_reg;
        pend_next = pend_reg;
        rng_next  = rng_reg;
        bom_next  = bom_reg;

        if (data_byte == 8'h00)
        begin
            bad_next = 1'b1;
        end

        if (pend_reg != 2'd0)
        begin
            if (cont_ok(data_byte, rng_reg))
            begin
                pend_next = pend_reg - 2'd1;
            end
            else
            begin
                bad_next  = 1'b1;
                pend_next = 2'd0;
            end
            rng_next = RNG_ANY;
        end
        else if (data_byte >= 8'h80)
        begin
            if (data_byte inside {[8'hC2:8'hDF]})
            begin
                pend_next = 2'd1;
                rng_next  = RNG_ANY;
            end
            else if (data_byte == 8'hE0)
            begin
                pend_next = 2'd2;
                rng_next  = RNG_A0BF;
            end
            else if (data_byte == 8'hED)
            begin
                pend_next = 2'd2;
                rng_next  = RNG_809F;
            end
            else if (data_byte inside {[8'hE1:8'hEF]})
            begin
                pend_next = 2'd2;
                rng_next  = RNG_ANY;
            end
            else if (data_byte == 8'hF0)
            begin
                pend_next = 2'd3;
                rng_next  = RNG_90BF;
            end
            else if (data_byte inside {[8'hF1:8'hF3]})
            begin
                pend_next = 2'd3;
                rng_next  = RNG_ANY;
            end
            else if (data_byte == 8'hF4)
            begin
                pend_next = 2'd3;
                rng_next  = RNG_808F;
            end
            else
            begin
                bad_next = 1'b1;
            end
        end

        if (ctl.bom_chk)
        begin
            if (bom_reg == ctl.bom_idx && data_byte == bom_byte(ctl.bom_idx))
            begin
                bom_next = ctl.bom_idx + 2'd1;
            end
            else
            begin
                bom_next = 2'd0;
            end
        end

        // a non-payload byte leaves the checker state alone, though a buffer end still clears it
        if (!ctl.feed)
        begin
            bad_next  = bad_reg;
            pend_next = pend_reg;
            rng_next  = rng_reg;
            bom_next  = bom_reg;
        end
    end

    assign stat.bad      = bad_next;
    assign stat.pending  = (pend_next != 2'd0);
    assign stat.bom_full = (bom_next == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg  <= 1'b0;
            pend_reg <= 2'd0;
            rng_reg  <= RNG_ANY;
            bom_reg  <= 2'd0;
        end
        else if (ctl.clear)
        begin
            bad_reg  <= 1'b0;
            pend_reg <= 2'd0;
            rng_reg  <= RNG_ANY;
            bom_reg  <= 2'd0;
        end
        else if (ctl.feed)
        begin
            bad_reg  <= bad_next;
            pend_reg <= pend_next;
            rng_reg  <= rng_next;
            bom_reg  <= bom_next;
        end
    end

endmodule

### rtl/ifv_frame.sv
// Frame tracker: byte count, header checks, length field and end-of-buffer status.
module ifv_frame
    import ifv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  in_beat_t    beat,
    input  logic [31:0] max_payload,
    output out_beat_t   result
);

    localparam logic [7:0] VERSION  = 8'd1;
    localparam logic [7:0] MSG_TYPE = 8'd1;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      len_reg, len_next;
    logic             hdr_bad_reg, hdr_bad_next;

    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] frame_len_cur;
    logic [CNT_W-1:0] frame_len_next;
    logic [CNT_W-1:0] pay_off;
    logic             in_payload;
    status_t          status;
    utf8_ctl_t        u_ctl;
    utf8_stat_t       u_stat;

    function automatic logic [7:0] magic_byte(input logic [1:0] i);
        logic [7:0] v;
        case (i)
            2'd0:    v = 8'h46;
            2'd1:    v = 8'h4D;
            2'd2:    v = 8'h49;
            default: v = 8'h50;
        endcase
        return v;
    endfunction

    always_comb
    begin
        pos          = count_reg;
        hdr_bad_next = hdr_bad_reg;
        len_next     = len_reg;

        if (pos < 34'd4)
        begin
            if (beat.data_byte != magic_byte(pos[1:0]))
            begin
                hdr_bad_next = 1'b1;
            end
        end
        else if (pos == 34'd4)
        begin
            if (beat.data_byte != VERSION)
            begin
                hdr_bad_next = 1'b1;
            end
        end
        else if (pos == 34'd5)
        begin
            if (beat.data_byte != MSG_TYPE)
            begin
                hdr_bad_next = 1'b1;
            end
        end
        else if (pos < HDR_LEN)
        begin
            len_next = {len_reg[23:0], beat.data_byte};
        end

        frame_len_cur = HDR_LEN + {2'b00, len_reg};
        in_payload    = (pos >= HDR_LEN) && (pos < frame_len_cur);
        pay_off       = pos - HDR_LEN;

        count_next = (count_reg == CNT_MAX) ? count_reg : count_reg + 34'd1;

        frame_len_next = HDR_LEN + {2'b00, len_next};

        // decision order matters: short header and short payload win over later checks
        status = ST_INCOMPLETE;
        if (beat.buffer_end)
        begin
            if (count_next < HDR_LEN)
            begin
                status = ST_INCOMPLETE;
            end
            else if (hdr_bad_next)
            begin
                status = ST_INVALID;
            end
            else if (len_next == 32'd0 || len_next > max_payload)
            begin
                status = ST_INVALID;
            end
            else if (count_next < frame_len_next)
            begin
                status = ST_INCOMPLETE;
            end
            else if (count_next != frame_len_next)
            begin
                status = ST_INVALID;
            end
            else if (u_stat.bad || u_stat.pending || (len_next == 32'd3 && u_stat.bom_full))
            begin
                status = ST_INVALID;
            end
            else
            begin
                status = ST_COMPLETE;
            end
        end
    end

    assign u_ctl.feed    = advance && in_payload;
    assign u_ctl.clear   = advance && beat.buffer_end;
    assign u_ctl.bom_chk = in_payload && (pay_off < 34'd3);
    assign u_ctl.bom_idx = pay_off[1:0];

    ifv_utf8 u_utf8 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (u_ctl),
        .data_byte (beat.data_byte),
        .stat      (u_stat)
    );

    assign result.out_byte       = beat.data_byte;
    assign result.is_payload     = in_payload;
    assign result.end_of_buffer  = beat.buffer_end;
    assign result.frame_status   = status;
    assign result.payload_length = len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            len_reg     <= '0;
            hdr_bad_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (beat.buffer_end)
            begin
                count_reg   <= '0;
                len_reg     <= '0;
                hdr_bad_reg <= 1'b0;
            end
            else
            begin
                count_reg   <= count_next;
                len_reg     <= len_next;
                hdr_bad_reg <= hdr_bad_next;
            end
        end
    end

endmodule

### verif/tb_ipc_frame_validator_core.sv
// Testbench for ipc_frame_validator_core: random and directed framed byte streams checked beat by beat.
`timescale 1ns / 1ps

module tb_ipc_frame_validator_core;
    import ifv_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam logic [7:0] PROTO_VERSION = 8'h01;
    localparam logic [7:0] MSG_TYPE      = 8'h01;
    localparam logic [7:0] MAGIC [4]     = '{8'h46, 8'h4D, 8'h49, 8'h50};
    localparam logic [7:0] BOM [3]       = '{8'hEF, 8'hBB, 8'hBF};

    // allowed window for the next UTF-8 continuation byte
    typedef enum logic [2:0] {
        CR_80_BF,
        CR_A0_BF,
        CR_80_9F,
        CR_90_BF,
        CR_80_8F
    } cont_range_t;

    typedef enum int unsigned {
        FK_GOOD,
        FK_BOM,
        FK_BOM_PREFIX,
        FK_ZERO,
        FK_OVERLONG,
        FK_SURROGATE,
        FK_TOO_HIGH,
        FK_STRAY_CONT,
        FK_MISSING_CONT,
        FK_TRUNCATED,
        FK_BAD_HEADER,
        FK_BAD_LEN,
        FK_SHORT_HDR,
        FK_SHORT_PAYLOAD,
        FK_EXCESS,
        FK_NOISE
    } frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_beat_t   out_data;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    // predictor state
    logic [31:0]      max_payload_q;
    logic [CNT_W-1:0] rx_count;
    logic [31:0]      decl_len;
    logic             hdr_bad;
    logic             pl_bad;
    logic [1:0]       utf8_left;
    cont_range_t      cont_rng;
    logic [1:0]       bom_seen;

    out_beat_t  predicted_beats[$];
    logic [7:0] frame_bytes[$];
    logic [7:0] pay_bytes[$];
    int         fail_count = 0;
    bit         tx_idle_en = 1'b1;
    bit         rx_idle_en = 1'b1;
    bit         hold_request = 1'b0;

    ipc_frame_validator_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic void clear_frame_state();
        rx_count  = '0;
        decl_len  = '0;
        hdr_bad   = 1'b0;
        pl_bad    = 1'b0;
        utf8_left = '0;
        cont_rng  = CR_80_BF;
        bom_seen  = '0;
    endfunction

    function automatic bit cont_in_range(input logic [7:0] b, input cont_range_t rng);
        case (rng)
            CR_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
            CR_80_9F: return b >= 8'h80 && b <= 8'h9F;
            CR_90_BF: return b >= 8'h90 && b <= 8'hBF;
            CR_80_8F: return b >= 8'h80 && b <= 8'h8F;
            default:  return b >= 8'h80 && b <= 8'hBF;
        endcase
    endfunction

    function automatic void decode_utf8(input logic [7:0] b);
        if (utf8_left != 0)
        begin
            if (cont_in_range(b, cont_rng))
                utf8_left = utf8_left - 2'd1;
            else
            begin
                pl_bad    = 1'b1;
                utf8_left = '0;
            end
            cont_rng = CR_80_BF;
        end
        else if (b >= 8'h80)
        begin
            cont_rng = CR_80_BF;
            if (b >= 8'hC2 && b <= 8'hDF)
                utf8_left = 2'd1;
            else if (b == 8'hE0)
            begin
                utf8_left = 2'd2;
                cont_rng  = CR_A0_BF;
            end
            else if (b == 8'hED)
            begin
                utf8_left = 2'd2;
                cont_rng  = CR_80_9F;
            end
            else if (b >= 8'hE1 && b <= 8'hEF)
                utf8_left = 2'd2;
            else if (b == 8'hF0)
            begin
                utf8_left = 2'd3;
                cont_rng  = CR_90_BF;
            end
            else if (b >= 8'hF1 && b <= 8'hF3)
                utf8_left = 2'd3;
            else if (b == 8'hF4)
            begin
                utf8_left = 2'd3;
                cont_rng  = CR_80_8F;
            end
            else
                pl_bad = 1'b1;
        end
    endfunction

    function automatic out_beat_t predict_beat(input logic [7:0] b, input logic is_last);
        out_beat_t        r;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] frame_len;
        logic             in_pl;
        status_t          st;
        pos   = rx_count;
        in_pl = 1'b0;
        st    = ST_INCOMPLETE;
        if (pos < 4)
        begin
            if (b != MAGIC[pos[1:0]])
                hdr_bad = 1'b1;
        end
        else if (pos == 4)
        begin
            if (b != PROTO_VERSION)
                hdr_bad = 1'b1;
        end
        else if (pos == 5)
        begin
            if (b != MSG_TYPE)
                hdr_bad = 1'b1;
        end
        else if (pos < HDR_LEN)
            decl_len = {decl_len[23:0], b};
        else if (pos - HDR_LEN < {2'b00, decl_len})
        begin
            in_pl = 1'b1;
            if (b == 8'h00)
                pl_bad = 1'b1;
            decode_utf8(b);
            if (pos - HDR_LEN < 3)
            begin
                if (bom_seen == pos[1:0] - HDR_LEN[1:0] && b == BOM[bom_seen])
                    bom_seen = bom_seen + 2'd1;
                else
                    bom_seen = '0;
            end
        end
        if (rx_count != CNT_MAX)
            rx_count = rx_count + 34'd1;
        if (is_last)
        begin
            frame_len = HDR_LEN + {2'b00, decl_len};
            if (rx_count < HDR_LEN)
                st = ST_INCOMPLETE;
            else if (hdr_bad)
                st = ST_INVALID;
            else if (decl_len == 0 || decl_len > max_payload_q)
                st = ST_INVALID;
            else if (rx_count < frame_len)
                st = ST_INCOMPLETE;
            else if (rx_count != frame_len)
                st = ST_INVALID;
            else if (pl_bad || utf8_left != 0 || (decl_len == 3 && bom_seen == 2'd3))
                st = ST_INVALID;
            else
                st = ST_COMPLETE;
        end
        r.out_byte       = b;
        r.is_payload     = in_pl;
        r.end_of_buffer  = is_last;
        r.frame_status   = st;
        r.payload_length = decl_len;
        if (is_last)
            clear_frame_state();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_beats.size() == 0)
            begin
                $error("result beat with nothing expected: out_byte 0x%0h", out_data.out_byte);
                fail_count++;
            end
            else
            begin
                want = predicted_beats.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(out_data.out_byte));
                check_field("is_payload", 32'(want.is_payload), 32'(out_data.is_payload));
                check_field("end_of_buffer", 32'(want.end_of_buffer),
                            32'(out_data.end_of_buffer));
                check_field("frame_status", 32'(want.frame_status),
                            32'(out_data.frame_status));
                check_field("payload_length", want.payload_length, out_data.payload_length);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, buffer_end: is_last};
        do
            @(posedge clk);
        while (!in_ready);
        predicted_beats.push_back(predict_beat(b, is_last));
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic wait_idle();
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        max_payload_q = value;
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic push_header(input logic [31:0] len, input bit corrupt);
        int unsigned idx;
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(MAGIC[i]);
        frame_bytes.push_back(PROTO_VERSION);
        frame_bytes.push_back(MSG_TYPE);
        frame_bytes.push_back(len[31:24]);
        frame_bytes.push_back(len[23:16]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        if (corrupt)
        begin
            idx = $urandom_range(0, 5);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
    endtask

    // appends n bytes of well-formed UTF-8 with no zero byte
    task automatic add_good_chars(input int unsigned n);
        int unsigned goal;
        int unsigned width;
        logic [7:0]  lead;
        goal = pay_bytes.size() + n;
        while (pay_bytes.size() < goal)
        begin
            width = $urandom_range(1, 4);
            if (width > goal - pay_bytes.size())
                width = goal - pay_bytes.size();
            case (width)
                1: pay_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
                2:
                begin
                    pay_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                    pay_bytes.push_back(rand_cont());
                end
                3:
                begin
                    lead = 8'($urandom_range(8'hE0, 8'hEF));
                    pay_bytes.push_back(lead);
                    if (lead == 8'hE0)
                        pay_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                    else if (lead == 8'hED)
                        pay_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                    else
                        pay_bytes.push_back(rand_cont());
                    pay_bytes.push_back(rand_cont());
                end
                default:
                begin
                    lead = 8'($urandom_range(8'hF0, 8'hF4));
                    pay_bytes.push_back(lead);
                    if (lead == 8'hF0)
                        pay_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                    else if (lead == 8'hF4)
                        pay_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                    else
                        pay_bytes.push_back(rand_cont());
                    pay_bytes.push_back(rand_cont());
                    pay_bytes.push_back(rand_cont());
                end
            endcase
        end
    endtask

    task automatic build_random_frame();
        frame_kind_t kind;
        int unsigned n;
        int unsigned cut;
        logic [31:0] len;
        logic [7:0]  lead;
        frame_bytes.delete();
        pay_bytes.delete();
        if ($urandom_range(0, 99) < 35)
            kind = FK_GOOD;
        else
            kind = frame_kind_t'($urandom_range(FK_BOM, FK_NOISE));

        if (kind == FK_NOISE)
        begin
            n = $urandom_range(1, 30);
            repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        case (kind)
            FK_BOM:
                foreach (BOM[i]) pay_bytes.push_back(BOM[i]);
            FK_BOM_PREFIX:
            begin
                foreach (BOM[i]) pay_bytes.push_back(BOM[i]);
                add_good_chars($urandom_range(1, 8));
            end
            FK_ZERO, FK_OVERLONG, FK_SURROGATE, FK_TOO_HIGH, FK_STRAY_CONT,
            FK_MISSING_CONT, FK_TRUNCATED:
            begin
                add_good_chars($urandom_range(0, 6));
                case (kind)
                    FK_ZERO: pay_bytes.push_back(8'h00);
                    FK_OVERLONG:
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                pay_bytes.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                                pay_bytes.push_back(rand_cont());
                            end
                            1:
                            begin
                                pay_bytes.push_back(8'hE0);
                                pay_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                                pay_bytes.push_back(rand_cont());
                            end
                            default:
                            begin
                                pay_bytes.push_back(8'hF0);
                                pay_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                                pay_bytes.push_back(rand_cont());
                                pay_bytes.push_back(rand_cont());
                            end
                        endcase
                    FK_SURROGATE:
                    begin
                        pay_bytes.push_back(8'hED);
                        pay_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                        pay_bytes.push_back(rand_cont());
                    end
                    FK_TOO_HIGH:
                        if ($urandom_range(0, 1) == 0)
                        begin
                            pay_bytes.push_back(8'hF4);
                            pay_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                            pay_bytes.push_back(rand_cont());
                            pay_bytes.push_back(rand_cont());
                        end
                        else
                            pay_bytes.push_back(8'($urandom_range(8'hF5, 8'hFF)));
                    FK_STRAY_CONT: pay_bytes.push_back(rand_cont());
                    FK_MISSING_CONT:
                    begin
                        pay_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                        pay_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    end
                    default:
                    begin
                        // sequence cut off by the end of the payload
                        lead = 8'($urandom_range(8'hC2, 8'hF4));
                        pay_bytes.push_back(lead);
                        if (lead >= 8'hE1 && lead <= 8'hEC && $urandom_range(0, 1) == 1)
                            pay_bytes.push_back(rand_cont());
                    end
                endcase
                if (kind != FK_TRUNCATED)
                    add_good_chars($urandom_range(0, 6));
            end
            FK_BAD_LEN:
            begin
                n = $urandom_range(0, 4);
                repeat (n) pay_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                n = $urandom_range(1, 16);
                if (n > max_payload_q)
                    n = max_payload_q;
                add_good_chars(n);
            end
        endcase

        len = pay_bytes.size();
        if (kind == FK_BAD_LEN)
            case ($urandom_range(0, 2))
                0: len = '0;
                1: len = 32'hFFFF_FFFF;
                default: len = max_payload_q + 32'd1;
            endcase
        push_header(len, kind == FK_BAD_HEADER);
        foreach (pay_bytes[i])
            frame_bytes.push_back(pay_bytes[i]);

        case (kind)
            FK_SHORT_HDR:
            begin
                cut = $urandom_range(1, 9);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
            FK_SHORT_PAYLOAD:
            begin
                cut = $urandom_range(10, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
            FK_EXCESS:
            begin
                n = $urandom_range(1, 4);
                repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endtask

    task automatic run_random_frames(input int unsigned n_items);
        int unsigned sent;
        sent = 0;
        while (sent < n_items)
        begin
            build_random_frame();
            send_frame();
            sent += frame_bytes.size();
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        // lone zero byte: header cut short
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        send_frame();
        // smallest good frame, top ASCII payload
        frame_bytes.delete();
        push_header(32'd1, 1'b0);
        frame_bytes.push_back(8'h7F);
        send_frame();
        // payload that is nothing but a byte-order mark
        frame_bytes.delete();
        push_header(32'd3, 1'b0);
        foreach (BOM[i]) frame_bytes.push_back(BOM[i]);
        send_frame();
        in_valid <= 1'b0;
    endtask

    task automatic test_reset_limit();
        run_random_frames(300);
        wait_idle();
    endtask

    task automatic test_limit_sweep();
        write_max_payload(32'd1);
        run_random_frames(200);
        wait_idle();
        write_max_payload(32'hFFFF_FFFF);
        run_random_frames(250);
        wait_idle();
        write_max_payload(32'($urandom_range(2, 24)));
        run_random_frames(300);
        wait_idle();
        write_max_payload(MAX_PAYLOAD_RESET);
        run_random_frames(250);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        while (hold_request)
            @(posedge clk);
        run_random_frames(60);
        tx_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_frames(300);
        wait_idle();
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        max_payload_q = MAX_PAYLOAD_RESET;
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_reset_limit();
        test_limit_sweep();
        test_output_backpressure();
        test_back_to_back();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/ifv_pkg.sv
rtl/ifv_utf8.sv
rtl/ifv_frame.sv
rtl/ipc_frame_validator_core.sv
verif/tb_ipc_frame_validator_core.sv
